@@ design/odsplit_pkg.sv @@
// shared types, constants and helpers for the ordered delimiter splitter
`timescale 1ns / 1ps
`default_nettype none
package odsplit_pkg;

    localparam int MAX_DELIMITERS = 8;
    localparam int BYTE_W         = 8;
    localparam int CNT_W          = 4;
    localparam int IDX_W          = 3;
    localparam int LIST_W         = MAX_DELIMITERS * BYTE_W;
    localparam int CFG_ADDR_W     = 1;
    localparam int OUT_DATA_W     = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DELIM_LIST  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELIM_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] TOKENS_MAX = CNT_W'(MAX_DELIMITERS + 1);

    // classified byte handed from the front to the back
    typedef struct packed {
        logic [BYTE_W-1:0]         data;
        logic                      last;
        logic                      in_set;
        logic [MAX_DELIMITERS-1:0] match;
    } t_cls;

    // delimiter count clamped to the list size
    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        res = cnt;
        if (cnt > CNT_W'(MAX_DELIMITERS)) begin
            res = CNT_W'(MAX_DELIMITERS);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ design/odsplit_front.sv @@
// front stage: takes bytes and compares them against the delimiter list
`timescale 1ns / 1ps
`default_nettype none
module odsplit_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [odsplit_pkg::LIST_W-1:0]        i_list,
    input  wire logic [odsplit_pkg::CNT_W-1:0]         i_count,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [odsplit_pkg::BYTE_W-1:0]        i_data,
    input  wire logic                                  i_last,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output odsplit_pkg::t_cls                          o_cls
);

    logic                      r_valid;
    odsplit_pkg::t_cls         r_cls;
    odsplit_pkg::t_cls         n_cls;
    logic [odsplit_pkg::MAX_DELIMITERS-1:0] w_match;

    // parallel compare, masked to the active part of the list
    always_comb begin
        for (int k = 0; k < odsplit_pkg::MAX_DELIMITERS; k++) begin
            w_match[k] = (i_list[k*odsplit_pkg::BYTE_W +: odsplit_pkg::BYTE_W] == i_data)
                         && (odsplit_pkg::CNT_W'(k) < i_count);
        end
        n_cls.data   = i_data;
        n_cls.last   = i_last;
        n_cls.match  = w_match;
        n_cls.in_set = |w_match;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule
`default_nettype wire

@@ design/odsplit_fifo.sv @@
// two-entry queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none
module odsplit_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire odsplit_pkg::t_cls i_cls,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output odsplit_pkg::t_cls      o_cls
);

    odsplit_pkg::t_cls r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cls   = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cls;
        end
    end

endmodule
`default_nettype wire

@@ design/odsplit_back.sv @@
// back stage: frame state, token numbering and the output register
`timescale 1ns / 1ps
`default_nettype none
module odsplit_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [odsplit_pkg::CNT_W-1:0]     i_count,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire odsplit_pkg::t_cls                 i_cls,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [odsplit_pkg::BYTE_W-1:0]         o_byte,
    output logic                                   o_is_char,
    output logic [odsplit_pkg::CNT_W-1:0]          o_tok_num,
    output logic                                   o_final,
    output logic                                   o_ok
);

    logic [odsplit_pkg::CNT_W-1:0] r_next;
    logic                          r_failed;
    logic                          r_inside;
    logic [odsplit_pkg::CNT_W-1:0] r_tokens;
    logic [odsplit_pkg::CNT_W-1:0] n_next;
    logic                          n_failed;
    logic                          n_inside;
    logic [odsplit_pkg::CNT_W-1:0] n_tokens;
    logic                          n_is_char;
    logic [odsplit_pkg::CNT_W-1:0] n_tok_num;
    logic                          n_ok;
    logic                          r_valid;
    logic                          w_take;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_next    = r_next;
        n_failed  = r_failed;
        n_inside  = r_inside;
        n_tokens  = r_tokens;
        n_is_char = 1'b0;
        n_tok_num = '0;
        if (i_cls.in_set) begin
            n_inside = 1'b0;
            if (r_next >= i_count) begin
                n_failed = 1'b1;
            end else begin
                // r_next is below the active count here, so it fits the index
                if (!i_cls.match[r_next[odsplit_pkg::IDX_W-1:0]]) begin
                    n_failed = 1'b1;
                end
                n_next = r_next + odsplit_pkg::CNT_W'(1);
            end
        end else begin
            n_is_char = 1'b1;
            if (!r_inside) begin
                n_inside = 1'b1;
                if (r_tokens < odsplit_pkg::TOKENS_MAX) begin
                    n_tokens = r_tokens + odsplit_pkg::CNT_W'(1);
                end
            end
            n_tok_num = n_tokens - odsplit_pkg::CNT_W'(1);
        end
        n_ok = i_cls.last && !n_failed && (i_count != '0) && (n_next == i_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_next   <= '0;
            r_failed <= 1'b0;
            r_inside <= 1'b0;
            r_tokens <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_take) begin
                if (i_cls.last) begin
                    r_next   <= '0;
                    r_failed <= 1'b0;
                    r_inside <= 1'b0;
                    r_tokens <= '0;
                end else begin
                    r_next   <= n_next;
                    r_failed <= n_failed;
                    r_inside <= n_inside;
                    r_tokens <= n_tokens;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            o_byte    <= i_cls.data;
            o_is_char <= n_is_char;
            o_tok_num <= n_tok_num;
            o_final   <= i_cls.last;
            o_ok      <= n_ok;
        end
    end

endmodule
`default_nettype wire

@@ design/ordered_delimiter_splitter.sv @@
// top level of the ordered delimiter splitter
// Splits a byte stream into tokens at an ordered list of up to eight delimiter
// bytes. Every input byte gives exactly one output request. A byte in the active
// part of the list is a delimiter (tuser 0) and must be the next delimiter in list
// order; anything else sets a sticky failure for the message. Other bytes are token
// characters (tuser 1) tagged with a 0-based token number; runs of delimiters make no
// empty tokens. The request for the last byte (tlast) carries frame_ok, set when no
// failure happened and every active delimiter was seen exactly once; the state then
// clears for the next message. Throughput is one byte per clock while the output is
// not stalled, passing through the compare register, two-entry queue and output
// register; updating the frame state in the back stage once per byte is what allows
// that rate. Write the configuration registers only while no byte is in flight.
`timescale 1ns / 1ps
`default_nettype none
module ordered_delimiter_splitter (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [odsplit_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [odsplit_pkg::LIST_W-1:0]         i_cfg_wdata,
    // byte input
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [7:0]                             s_axis_tdata,  // data_byte
    input  wire logic                                   s_axis_tlast,  // last_byte
    // result output
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [odsplit_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // token_byte,
                                                                       // token_number,
                                                                       // frame_ok, zero pad
    output logic [0:0]                                  m_axis_tuser,  // is_token_char
    output logic                                        m_axis_tlast   // is_final
);

    logic [odsplit_pkg::LIST_W-1:0] r_list;
    logic [odsplit_pkg::CNT_W-1:0]  r_count;
    logic [odsplit_pkg::CNT_W-1:0]  w_count;

    logic              w_f_valid;
    logic              w_f_ready;
    odsplit_pkg::t_cls w_f_cls;
    logic              w_q_valid;
    logic              w_q_ready;
    odsplit_pkg::t_cls w_q_cls;

    logic [odsplit_pkg::BYTE_W-1:0] w_byte;
    logic [odsplit_pkg::CNT_W-1:0]  w_tok_num;
    logic                           w_ok;
    logic                           w_is_char;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list  <= '0;
            r_count <= odsplit_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                odsplit_pkg::CFG_DELIM_LIST:  r_list  <= i_cfg_wdata;
                odsplit_pkg::CFG_DELIM_COUNT: r_count <= i_cfg_wdata[odsplit_pkg::CNT_W-1:0];
                default:                      r_list  <= r_list;
            endcase
        end
    end

    // counts above the list size act as a full list
    assign w_count = odsplit_pkg::active_count(r_count);

    odsplit_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_list  (r_list),
        .i_count (w_count),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_cls   (w_f_cls)
    );

    // lets the compare stage run ahead while the output stalls
    odsplit_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_cls   (w_f_cls),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cls   (w_q_cls)
    );

    odsplit_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_count   (w_count),
        .i_valid   (w_q_valid),
        .o_ready   (w_q_ready),
        .i_cls     (w_q_cls),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (w_byte),
        .o_is_char (w_is_char),
        .o_tok_num (w_tok_num),
        .o_final   (m_axis_tlast),
        .o_ok      (w_ok)
    );

    assign m_axis_tdata = {3'b000, w_ok, w_tok_num, w_byte};
    assign m_axis_tuser = w_is_char;

endmodule
`default_nettype wire

@@ design/odsplit_checker.sv @@
// port-level checker for the ordered delimiter splitter and its bind
`timescale 1ns / 1ps
`default_nettype none
module odsplit_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // stalled output request holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output request changed while stalled");

    // delimiters carry token number zero
    a_delim_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[11:8] == 4'd0)
        else $error("delimiter with nonzero token number");

    // frame status only on the last byte
    a_ok_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[12])
        else $error("frame_ok on a non-final byte");

    // token number saturates at the list size
    a_tok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:8] <= 4'd8)
        else $error("token number out of range");

    // reset empties the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind ordered_delimiter_splitter odsplit_checker u_odsplit_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
